// ===== hdl/scbnd_pkg.sv =====
package scbnd_pkg;

	// Bus write word, oldest field first
	typedef struct packed {
		logic        chip_select;
		logic [1:0]  port_index;
		logic [7:0]  write_data;
		logic [31:0] frame_number;
	} bus_word_t;

	// Note event word
	typedef struct packed {
		logic [31:0] event_frame;
		logic        event_chip;
		logic [2:0]  event_channel;
		logic        is_note_on;
		logic [6:0]  midi_note;
		logic [6:0]  note_velocity;
		logic [63:0] timbre_signature;
	} note_word_t;

	// Work handed from front to back
	typedef enum logic [1:0] {
		CK_NONE,
		CK_FM_ON,
		CK_PSG_ON,
		CK_OFF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        do_write;
		logic [8:0]  waddr;
		logic [7:0]  wdata;
		logic [31:0] frame;
		logic        chip;
		logic [2:0]  ch;
		logic [9:0]  period;
		logic [6:0]  vel;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_LAST,
		BK_FIN,
		BK_CHECK,
		BK_SEARCH,
		BK_EMIT
	} bk_state_t;

	localparam int FM_REGS = 512;
	localparam int FM_AW = 9;
	localparam logic [8:0] FM_KEY_REG = 9'h028;
	localparam logic [8:0] FM_DAC_REG = 9'h02B;
	localparam logic [7:0] FM_ALG_BASE = 8'hB0;
	localparam logic [7:0] FM_FHI_BASE = 8'hA4;
	localparam logic [7:0] FM_FLO_BASE = 8'hA0;
	localparam logic [7:0] FM_OP_BASE = 8'h30;
	localparam logic [4:0] LAST_STEP = 5'd30;
	localparam logic [22:0] FM_CLOCK_NUM = 23'd7670453;
	localparam logic [40:0] FM_MIN_SCALED = 41'd4831838208;
	localparam logic [63:0] PSG_CLOCK = 64'd3579545;
	localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [63:0] Q62_ONE = 64'h4000000000000000;
	localparam logic [6:0] VEL_MAX = 7'd127;
	localparam logic [3:0] PSG_SILENT = 4'hF;
	localparam logic [9:0] PSG_MIN_PERIOD = 10'd9;

	localparam logic [7:0][3:0] CARRIER_SETS =
		{4'hF, 4'hE, 4'hE, 4'hA, 4'h8, 4'h8, 4'h8, 4'h8};

	typedef logic [11:0][63:0] bound_tab_t;

	// Bits [s+63:s] of a 128-bit product
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic logic root_not_above(input logic [63:0] r);
		logic [63:0] acc;
		logic ok;
		acc = Q62_ONE;
		ok = 1'b1;
		for (int i = 0; i < 24; i++) begin
			acc = mul_shift(acc, r, 62);
			if (acc > {Q62_ONE[62:0], 1'b0})
				ok = 1'b0;
		end
		return ok;
	endfunction

	// Rounding boundaries of the twelve pitch classes, 37 fraction bits
	function automatic bound_tab_t build_bounds();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] t;
		bound_tab_t tab;
		lo = Q62_ONE;
		hi = Q62_ONE + (Q62_ONE >> 4);
		t = Q62_ONE;
		while (hi - lo > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			if (root_not_above(mid))
				lo = mid;
			else
				hi = mid;
		end
		for (int i = 0; i < 5; i++)
			t = mul_shift(t, lo, 62);
		for (int i = 0; i < 12; i++) begin
			tab[i] = mul_shift(t, 64'd55, 25);
			t = mul_shift(mul_shift(t, lo, 62), lo, 62);
		end
		return tab;
	endfunction

	localparam bound_tab_t BOUND_TAB = build_bounds();

	function automatic logic [63:0] fm_rhs(input logic [3:0] r);
		return 64'd9 * BOUND_TAB[r];
	endfunction

	function automatic logic [63:0] psg_lhs(input logic [3:0] q);
		return PSG_CLOCK << (6'd35 - {2'b0, q});
	endfunction

	// Octave of a note number
	function automatic logic [3:0] div12(input logic [6:0] k);
		logic [3:0] q;
		q = 4'd0;
		for (int j = 1; j <= 10; j++)
			if (k >= 7'(12 * j))
				q = 4'(j);
		return q;
	endfunction

	// One FNV-1a byte step; the prime is 2^40 + 0x1B3
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		logic [63:0] m;
		x = h ^ {56'b0, b};
		m = x * {55'b0, FNV_PRIME[8:0]};
		return (x << 40) + m;
	endfunction

endpackage

// ===== hdl/scbnd_ram.sv =====
module scbnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/scbnd_front.sv =====
module scbnd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  scbnd_pkg::bus_word_t word,
	output logic                 cmd_v,
	output scbnd_pkg::cmd_t      cmd
);
	import scbnd_pkg::*;

	logic [8:0] addr_q, addr_d;
	logic       dac_q, dac_d;
	logic [3:0] mask_q [6];
	logic [3:0] mask_d [6];
	logic [9:0] period_q [4];
	logic [9:0] period_d [4];
	logic [3:0] att_q [4];
	logic [3:0] att_d [4];
	logic [2:0] tgt_q, tgt_d;

	logic [8:0] reg_a;
	logic [2:0] sel;
	logic [2:0] fm_ch;
	logic       was;
	logic [1:0] pch;
	logic [3:0] att_new;

	// Classify one bus word, update shadow state
	always_comb begin
		addr_d = addr_q;
		dac_d = dac_q;
		mask_d = mask_q;
		period_d = period_q;
		att_d = att_q;
		tgt_d = tgt_q;
		cmd_v = 1'b0;
		cmd = '0;
		cmd.kind = CK_NONE;
		cmd.frame = word.frame_number;
		reg_a = addr_q;
		sel = word.write_data[2:0];
		fm_ch = {1'b0, sel[1:0]} + (sel[2] ? 3'd3 : 3'd0);
		was = 1'b0;
		pch = word.write_data[6:5];
		att_new = word.write_data[3:0];
		if (!word.chip_select) begin
			unique case (word.port_index)
				2'd0: addr_d = {1'b0, word.write_data};
				2'd2: addr_d = {1'b1, word.write_data};
				default: begin
					cmd_v = 1'b1;
					cmd.do_write = 1'b1;
					cmd.waddr = reg_a;
					cmd.wdata = word.write_data;
					cmd.chip = 1'b0;
					cmd.ch = fm_ch;
					if (reg_a == FM_DAC_REG)
						dac_d = word.write_data[7];
					if (reg_a == FM_KEY_REG && sel[1:0] != 2'd3) begin
						was = mask_q[fm_ch] != 4'd0;
						mask_d[fm_ch] = word.write_data[7:4];
						if (word.write_data[7:4] != 4'd0 && !was) begin
							if (!(fm_ch == 3'd5 && dac_q))
								cmd.kind = CK_FM_ON;
						end else if (word.write_data[7:4] == 4'd0 && was) begin
							cmd.kind = CK_OFF;
						end
					end
				end
			endcase
		end else if (word.write_data[7]) begin
			// Latch byte
			tgt_d = word.write_data[6:4];
			cmd.chip = 1'b1;
			cmd.ch = {1'b0, pch};
			if (word.write_data[4]) begin
				was = att_q[pch] < PSG_SILENT;
				att_d[pch] = att_new;
				cmd.period = period_q[pch];
				cmd.vel = VEL_MAX - {att_new[3:0], 3'b0};
				if (att_new < PSG_SILENT && !was && pch != 2'd3) begin
					cmd_v = 1'b1;
					cmd.kind = CK_PSG_ON;
				end else if (att_new == PSG_SILENT && was) begin
					cmd_v = 1'b1;
					cmd.kind = CK_OFF;
				end
			end else if (pch != 2'd3) begin
				period_d[pch] = {period_q[pch][9:4], word.write_data[3:0]};
			end
		end else begin
			// Data byte: high bits of the latched tone period
			if (!tgt_q[0] && tgt_q[2:1] != 2'd3)
				period_d[tgt_q[2:1]] = {word.write_data[5:0], period_q[tgt_q[2:1]][3:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			dac_q <= 1'b0;
			tgt_q <= '0;
			for (int i = 0; i < 6; i++)
				mask_q[i] <= '0;
			for (int i = 0; i < 4; i++) begin
				period_q[i] <= '0;
				att_q[i] <= PSG_SILENT;
			end
		end else if (accept) begin
			addr_q <= addr_d;
			dac_q <= dac_d;
			tgt_q <= tgt_d;
			mask_q <= mask_d;
			period_q <= period_d;
			att_q <= att_d;
		end
	end
endmodule

// ===== hdl/scbnd_cmdq.sv =====
module scbnd_cmdq #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_v,
	input  scbnd_pkg::cmd_t push_cmd,
	output logic            full,
	output logic            head_v,
	output scbnd_pkg::cmd_t head,
	input  logic            pop
);
	import scbnd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign head_v = cnt_q != '0;
	assign head = mem_q[rd_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_v)
			mem_q[wr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_v)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push_v) - CW'(pop);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_v && full && !pop))
		else $error("command pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_v)
		else $error("command popped from empty queue");
endmodule

// ===== hdl/scbnd_back.sv =====
module scbnd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_v,
	input  scbnd_pkg::cmd_t       head,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_v,
	output scbnd_pkg::note_word_t out_word,
	input  logic                  pop
);
	import scbnd_pkg::*;

	bk_state_t   state_q, state_d;
	cmd_t        cur_q;
	logic [8:0]  clr_q;
	logic [4:0]  step_q;
	logic [1:0]  op_q;
	logic [2:0]  r_q;
	logic        rd_v_s1;
	logic [4:0]  rd_step_s1;
	logic [1:0]  rd_op_s1;
	logic [2:0]  rd_r_s1;
	logic [7:0]  alg_q, hi_q, lo_q;
	logic [6:0]  best_q;
	logic [63:0] hash_q;
	logic [40:0] scaled_q;
	logic [6:0]  note_q;
	logic [2:0]  bit_q;
	logic        out_v_q;
	note_word_t  out_q;

	logic        ram_we;
	logic [8:0]  ram_waddr;
	logic [7:0]  ram_wdata;
	logic [8:0]  ram_raddr;
	logic [7:0]  ram_rdata;
	logic        bank;
	logic [1:0]  idx;
	logic [7:0]  low_addr;
	logic [6:0]  try_note;
	logic [3:0]  oct;
	logic [3:0]  pcls;
	logic        hit;
	logic        drop;
	logic        out_load;
	note_word_t  out_d;
	logic [17:0] pitch;
	logic        carrier;

	scbnd_ram #(.WIDTH(8), .DEPTH(FM_REGS)) u_regs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Register address of the current read step
	always_comb begin
		bank = cur_q.ch >= 3'd3;
		idx = bank ? 2'(cur_q.ch - 3'd3) : cur_q.ch[1:0];
		unique case (step_q)
			5'd0: low_addr = FM_ALG_BASE + {6'b0, idx};
			5'd1: low_addr = FM_FHI_BASE + {6'b0, idx};
			5'd2: low_addr = FM_FLO_BASE + {6'b0, idx};
			default: low_addr = FM_OP_BASE + {4'b0, op_q, 2'b0} + {6'b0, idx}
				+ {1'b0, r_q, 4'b0};
		endcase
		ram_raddr = {bank, low_addr};
	end

	// Boundary compare for one trial note
	always_comb begin
		try_note = note_q | (7'd1 << bit_q);
		oct = div12(try_note);
		pcls = 4'(try_note - ({3'b0, oct} * 7'd12));
		if (cur_q.kind == CK_PSG_ON)
			hit = psg_lhs(oct) >= ({54'b0, cur_q.period} * BOUND_TAB[pcls]);
		else
			hit = ({23'b0, scaled_q} << (4'd15 - oct)) >= fm_rhs(pcls);
	end

	assign pitch = 18'({hi_q[2:0], lo_q}) << hi_q[5:3];
	assign carrier = CARRIER_SETS[alg_q[2:0]][rd_op_s1];
	assign drop = cur_q.kind != CK_OFF && note_q == 7'd0;

	// Result word
	always_comb begin
		out_d.event_frame = cur_q.frame;
		out_d.event_chip = cur_q.chip;
		out_d.event_channel = cur_q.ch;
		out_d.is_note_on = cur_q.kind != CK_OFF;
		out_d.midi_note = '0;
		out_d.note_velocity = '0;
		out_d.timbre_signature = '0;
		unique case (cur_q.kind)
			CK_FM_ON: begin
				out_d.midi_note = note_q;
				out_d.note_velocity = (best_q >= 7'd126) ? 7'd1 : VEL_MAX - best_q;
				out_d.timbre_signature = (hash_q == '0) ? 64'd1 : hash_q;
			end
			CK_PSG_ON: begin
				out_d.midi_note = note_q;
				out_d.note_velocity = cur_q.vel;
			end
			default: ;
		endcase
	end

	// Sequencer next state and control
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		ram_we = 1'b0;
		ram_waddr = head.waddr;
		ram_wdata = head.wdata;
		out_load = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == 9'(FM_REGS - 1))
					state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (head_v) begin
					q_pop = 1'b1;
					ram_we = head.do_write;
					unique case (head.kind)
						CK_NONE: state_d = BK_IDLE;
						CK_FM_ON: state_d = BK_READ;
						CK_PSG_ON: state_d = (head.period < PSG_MIN_PERIOD) ? BK_IDLE
							: BK_SEARCH;
						CK_OFF: state_d = BK_EMIT;
					endcase
				end
			end
			BK_READ: if (step_q == LAST_STEP) state_d = BK_LAST;
			BK_LAST: state_d = BK_FIN;
			BK_FIN: state_d = BK_CHECK;
			BK_CHECK: state_d = (scaled_q < FM_MIN_SCALED) ? BK_IDLE : BK_SEARCH;
			BK_SEARCH: if (bit_q == 3'd0) state_d = BK_EMIT;
			BK_EMIT: begin
				if (drop) begin
					state_d = BK_IDLE;
				end else if (!out_v_q || pop) begin
					out_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR)
				clr_q <= clr_q + 1'b1;
			rd_v_s1 <= state_q == BK_READ;
			if (out_load)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_d;
		rd_step_s1 <= step_q;
		rd_op_s1 <= op_q;
		rd_r_s1 <= r_q;
		if (q_pop) begin
			cur_q <= head;
			step_q <= '0;
			op_q <= '0;
			r_q <= '0;
			hash_q <= FNV_OFFSET;
			best_q <= VEL_MAX;
			note_q <= '0;
			bit_q <= 3'd6;
		end
		if (state_q == BK_READ) begin
			step_q <= step_q + 1'b1;
			if (step_q >= 5'd3) begin
				if (r_q == 3'd6) begin
					r_q <= '0;
					op_q <= op_q + 1'b1;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
		end
		// Consume the word read in the previous cycle
		if (rd_v_s1) begin
			unique case (rd_step_s1)
				5'd0: alg_q <= ram_rdata;
				5'd1: hi_q <= ram_rdata;
				5'd2: lo_q <= ram_rdata;
				default: begin
					if (rd_r_s1 == 3'd1 && carrier) begin
						if (ram_rdata[6:0] < best_q)
							best_q <= ram_rdata[6:0];
					end else begin
						hash_q <= fnv_step(hash_q, ram_rdata);
					end
				end
			endcase
		end
		if (state_q == BK_FIN) begin
			hash_q <= fnv_step(hash_q, alg_q);
			scaled_q <= 41'(pitch) * 41'(FM_CLOCK_NUM);
		end
		if (state_q == BK_SEARCH) begin
			if (hit)
				note_q <= try_note;
			bit_q <= bit_q - 1'b1;
		end
	end

	assign clearing = state_q == BK_CLEAR;
	assign out_v = out_v_q;
	assign out_word = out_q;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |-> !q_pop)
		else $error("command taken during register clear");
	a_fm_sig: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !out_d.event_chip && out_d.is_note_on |-> out_d.timbre_signature != '0)
		else $error("FM note on with zero signature");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !out_d.is_note_on |->
		out_d.midi_note == '0 && out_d.note_velocity == '0 && out_d.timbre_signature == '0)
		else $error("note off carries payload");
	a_on_note: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.is_note_on |-> out_d.midi_note != '0)
		else $error("note on with note zero");
endmodule

// ===== hdl/sound_chip_bus_note_decoder.sv =====
// Channel   Handshake          Word
// write     push / full        write_word  (bus_word_t)
// event     empty / pop        event_word  (note_word_t)
//
// The front takes each pushed bus word in that cycle unless full is high. After reset
// full stays high while the register RAM is cleared one entry per cycle. The back takes
// a register write while idle; a note off goes straight to emit; a PSG note on runs the
// note search; an FM note on makes 31 reads through the RAM's one read port, then a
// 7-step note search. A waiting event stalls the back, and a full queue the front.
module sound_chip_bus_note_decoder #(
	parameter int CMDQ_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  scbnd_pkg::bus_word_t   write_word,
	output logic                   empty,
	input  logic                   pop,
	output scbnd_pkg::note_word_t  event_word
);
	import scbnd_pkg::*;

	logic  accept;
	logic  cmd_v;
	cmd_t  cmd;
	logic  q_full;
	logic  head_v;
	cmd_t  head;
	logic  q_pop;
	logic  clearing;
	logic  out_v;

	assign full = q_full || clearing;
	assign accept = push && !full;
	assign empty = !out_v;

	scbnd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.word   (write_word),
		.cmd_v  (cmd_v),
		.cmd    (cmd)
	);

	scbnd_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_v   (accept && cmd_v),
		.push_cmd (cmd),
		.full     (q_full),
		.head_v   (head_v),
		.head     (head),
		.pop      (q_pop)
	);

	scbnd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_v   (head_v),
		.head     (head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.out_v    (out_v),
		.out_word (event_word),
		.pop      (pop && out_v)
	);
endmodule

// ===== bench/tb_sound_chip_bus_note_decoder.sv =====
module tb_sound_chip_bus_note_decoder;
	import scbnd_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int LONG_HOLD = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	bus_word_t write_word = '0;
	note_word_t event_word;

	sound_chip_bus_note_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.write_word(write_word),
		.empty(empty),
		.pop(pop),
		.event_word(event_word)
	);

	always #10 clk = ~clk;

	// bus words waiting to be sent, note events waiting to come out
	bus_word_t bus_pending[$];
	note_word_t notes_due[$];
	int errors = 0;
	int notes_seen = 0;
	bit quiet = 1'b0;
	bit long_hold_done = 1'b0;

	// shadow of the chip state
	logic [7:0] shadow_regs[512];
	logic [8:0] shadow_addr;
	logic shadow_dac;
	logic [3:0] shadow_keys[6];
	logic [9:0] shadow_period[4];
	logic [3:0] shadow_atten[4];
	logic [2:0] shadow_target;
	logic [63:0] pitch_bounds[12];

	function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b,
		input int sh);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return 64'(prod >> sh);
	endfunction

	// boundaries from the 24th root of two found by bisection in Q2.62
	task automatic make_pitch_bounds();
		logic [63:0] one_q;
		logic [63:0] lo_r;
		logic [63:0] hi_r;
		logic [63:0] mid_r;
		logic [63:0] acc;
		logic [63:0] step_r;
		bit ok;
		one_q = 64'h4000000000000000;
		lo_r = one_q;
		hi_r = one_q + (one_q >> 4);
		while (hi_r - lo_r > 1) begin
			mid_r = lo_r + ((hi_r - lo_r) >> 1);
			acc = one_q;
			ok = 1'b1;
			for (int i = 0; i < 24 && ok; i++) begin
				acc = fixed_mul(acc, mid_r, 62);
				if (acc > (one_q << 1))
					ok = 1'b0;
			end
			if (ok)
				lo_r = mid_r;
			else
				hi_r = mid_r;
		end
		step_r = one_q;
		for (int i = 0; i < 5; i++)
			step_r = fixed_mul(step_r, lo_r, 62);
		for (int j = 0; j < 12; j++) begin
			pitch_bounds[j] = fixed_mul(step_r, 64'd55, 25);
			step_r = fixed_mul(fixed_mul(step_r, lo_r, 62), lo_r, 62);
		end
	endtask

	function automatic logic [6:0] fm_pitch_note(input int ch);
		int bank;
		int idx;
		logic [7:0] fhi;
		logic [7:0] flo;
		logic [63:0] scaled;
		logic [6:0] note;
		bank = (ch < 3) ? 0 : 256;
		idx = ch % 3;
		fhi = shadow_regs[bank + 'hA4 + idx];
		flo = shadow_regs[bank + 'hA0 + idx];
		scaled = (64'({fhi[2:0], flo}) << fhi[5:3]) * 64'd7670453;
		note = 0;
		if (scaled < 64'd4831838208)
			return 0;
		for (int k = 1; k < 128; k++)
			if ((scaled << (15 - k / 12)) >= 64'd9 * pitch_bounds[k % 12])
				note = 7'(k);
		return note;
	endfunction

	function automatic logic [6:0] psg_pitch_note(input logic [9:0] period);
		logic [6:0] note;
		note = 0;
		if (period < 10'd9)
			return 0;
		for (int k = 1; k < 128; k++)
			if ((64'd3579545 << (35 - k / 12)) >= 64'(period) * pitch_bounds[k % 12])
				note = 7'(k);
		return note;
	endfunction

	function automatic logic [6:0] fm_carrier_velocity(input int ch);
		int bank;
		int idx;
		logic [3:0] carriers;
		logic [6:0] best;
		logic [6:0] tl;
		bank = (ch < 3) ? 0 : 256;
		idx = ch % 3;
		carriers = CARRIER_SETS[shadow_regs[bank + 'hB0 + idx][2:0]];
		best = 127;
		for (int op = 0; op < 4; op++)
			if (carriers[op]) begin
				tl = shadow_regs[(bank + 'h40 + op * 4 + idx) & 'h1FF][6:0];
				if (tl < best)
					best = tl;
			end
		return (best >= 126) ? 7'd1 : 7'(127 - best);
	endfunction

	// FNV-1a over the operator registers, carrier levels left out, then the algorithm register
	function automatic logic [63:0] fm_timbre_hash(input int ch);
		int bank;
		int idx;
		logic [7:0] alg;
		logic [3:0] carriers;
		logic [63:0] h;
		bank = (ch < 3) ? 0 : 256;
		idx = ch % 3;
		alg = shadow_regs[bank + 'hB0 + idx];
		carriers = CARRIER_SETS[alg[2:0]];
		h = 64'd1469598103934665603;
		for (int op = 0; op < 4; op++)
			for (int r = 0; r < 7; r++)
				if (!(r == 1 && carriers[op]))
					h = (h ^ 64'(shadow_regs[(bank + 'h30 + op * 4 + idx + r * 'h10) & 'h1FF]))
						* 64'd1099511628211;
		h = (h ^ 64'(alg)) * 64'd1099511628211;
		return (h == 0) ? 64'd1 : h;
	endfunction

	task automatic add_note(input logic [31:0] frame, input logic chip, input int ch,
		input logic on, input logic [6:0] note, input logic [6:0] vel, input logic [63:0] sig);
		note_word_t n;
		n.event_frame = frame;
		n.event_chip = chip;
		n.event_channel = 3'(ch);
		n.is_note_on = on;
		n.midi_note = note;
		n.note_velocity = vel;
		n.timbre_signature = sig;
		notes_due.insert(notes_due.size(), n);
	endtask

	// track one accepted bus word, queue the note event it causes
	task automatic decode_bus_word(input bus_word_t w);
		logic [7:0] d;
		logic [8:0] reg_a;
		int ch;
		logic [3:0] ops;
		bit was;
		logic [6:0] note;
		logic [3:0] a;
		d = w.write_data;
		if (w.chip_select == 1'b0) begin
			if (w.port_index == 2'd0) begin
				shadow_addr = {1'b0, d};
				return;
			end
			if (w.port_index == 2'd2) begin
				shadow_addr = {1'b1, d};
				return;
			end
			reg_a = shadow_addr;
			shadow_regs[reg_a] = d;
			if (reg_a == FM_DAC_REG) begin
				shadow_dac = d[7];
				return;
			end
			if (reg_a != FM_KEY_REG || d[1:0] == 2'd3)
				return;
			ch = d[1:0] + (d[2] ? 3 : 0);
			ops = d[7:4];
			was = shadow_keys[ch] != 0;
			shadow_keys[ch] = ops;
			if (ops != 0 && !was) begin
				if (ch == 5 && shadow_dac)
					return;
				note = fm_pitch_note(ch);
				if (note != 0)
					add_note(w.frame_number, 1'b0, ch, 1'b1, note,
						fm_carrier_velocity(ch), fm_timbre_hash(ch));
			end else if (ops == 0 && was) begin
				add_note(w.frame_number, 1'b0, ch, 1'b0, 0, 0, 0);
			end
			return;
		end
		if (d[7]) begin
			shadow_target = d[6:4];
			ch = shadow_target[2:1];
			if (shadow_target[0]) begin
				a = d[3:0];
				was = shadow_atten[ch] < 15;
				shadow_atten[ch] = a;
				if (a < 15 && !was) begin
					note = (ch < 3) ? psg_pitch_note(shadow_period[ch]) : 7'd0;
					if (note != 0)
						add_note(w.frame_number, 1'b1, ch, 1'b1, note, 7'(127 - a * 8), 0);
				end else if (a == 15 && was) begin
					add_note(w.frame_number, 1'b1, ch, 1'b0, 0, 0, 0);
				end
			end else if (ch < 3) begin
				shadow_period[ch][3:0] = d[3:0];
			end
		end else begin
			ch = shadow_target[2:1];
			if (!shadow_target[0] && ch < 3)
				shadow_period[ch][9:4] = d[5:0];
		end
	endtask

	// sender: offers the oldest pending word, idles in random bursts
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			write_word <= '0;
			send_gap = 0;
		end else begin
			if (push && !full) begin
				decode_bus_word(write_word);
				void'(bus_pending.pop_front());
			end
			if (send_gap == 0 && !quiet && $urandom_range(0, 19) == 0)
				send_gap = $urandom_range(1, 16);
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (bus_pending.size() > 0) begin
				push <= 1'b1;
				write_word <= bus_pending[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: checks each event word against the oldest prediction
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			if (pop && !empty) begin
				notes_seen++;
				if (notes_due.size() == 0) begin
					$error("unexpected event word %h", event_word);
					errors++;
				end else begin
					note_word_t e;
					e = notes_due.pop_front();
					if (event_word.event_frame !== e.event_frame) begin
						$error("event_frame exp %h got %h", e.event_frame, event_word.event_frame);
						errors++;
					end
					if (event_word.event_chip !== e.event_chip) begin
						$error("event_chip exp %h got %h", e.event_chip, event_word.event_chip);
						errors++;
					end
					if (event_word.event_channel !== e.event_channel) begin
						$error("event_channel exp %0d got %0d", e.event_channel,
							event_word.event_channel);
						errors++;
					end
					if (event_word.is_note_on !== e.is_note_on) begin
						$error("is_note_on exp %b got %b", e.is_note_on, event_word.is_note_on);
						errors++;
					end
					if (event_word.midi_note !== e.midi_note) begin
						$error("midi_note exp %0d got %0d", e.midi_note, event_word.midi_note);
						errors++;
					end
					if (event_word.note_velocity !== e.note_velocity) begin
						$error("note_velocity exp %0d got %0d", e.note_velocity,
							event_word.note_velocity);
						errors++;
					end
					if (event_word.timbre_signature !== e.timbre_signature) begin
						$error("timbre_signature exp %h got %h", e.timbre_signature,
							event_word.timbre_signature);
						errors++;
					end
				end
			end
			// one long hold so the command queue backs up into full
			if (!long_hold_done && notes_seen == 30) begin
				long_hold_done = 1'b1;
				recv_gap = LONG_HOLD;
			end else if (recv_gap == 0 && !quiet && $urandom_range(0, 19) == 0) begin
				recv_gap = $urandom_range(1, 16);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog on handshake progress
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	int words_queued = 0;

	task automatic queue_word(input logic chip, input logic [1:0] port, input logic [7:0] d);
		bus_word_t w;
		w.chip_select = chip;
		w.port_index = port;
		w.write_data = d;
		w.frame_number = $urandom;
		bus_pending.insert(bus_pending.size(), w);
		words_queued++;
	endtask

	// FM register write: address then data on either data port
	task automatic fm_write(input int bank, input logic [7:0] reg_a, input logic [7:0] d);
		queue_word(1'b0, bank ? 2'd2 : 2'd0, reg_a);
		queue_word(1'b0, $urandom_range(0, 1) ? 2'd3 : 2'd1, d);
	endtask

	task automatic fm_key(input int ch, input logic [3:0] ops);
		fm_write(0, FM_KEY_REG[7:0], {ops, 1'b0, ch >= 3, 2'(ch % 3)});
	endtask

	task automatic fm_voice_setup(input int ch, input bit full_patch);
		int bank;
		int idx;
		bank = ch >= 3;
		idx = ch % 3;
		fm_write(bank, 8'hA4 + 8'(idx), 8'($urandom));
		fm_write(bank, 8'hA0 + 8'(idx), 8'($urandom));
		if (full_patch) begin
			fm_write(bank, 8'hB0 + 8'(idx), 8'($urandom));
			for (int n = 0; n < 6; n++)
				fm_write(bank, 8'($urandom_range('h30, 'h9F) & 'hFC) + 8'(idx), 8'($urandom));
		end
	endtask

	task automatic psg_period_set(input int ch, input logic [9:0] period);
		queue_word(1'b1, 2'($urandom), {1'b1, 2'(ch), 1'b0, period[3:0]});
		queue_word(1'b1, 2'($urandom), {1'b0, 1'($urandom), period[9:4]});
	endtask

	task automatic psg_atten(input int ch, input logic [3:0] a);
		queue_word(1'b1, 2'($urandom), {1'b1, 2'(ch), 1'b1, a});
	endtask

	task automatic wait_drained();
		while (bus_pending.size() != 0 || notes_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int ch;
		for (int i = 0; i < 512; i++)
			shadow_regs[i] = 8'h00;
		shadow_addr = 0;
		shadow_dac = 1'b0;
		for (int i = 0; i < 6; i++)
			shadow_keys[i] = 0;
		for (int i = 0; i < 4; i++) begin
			shadow_period[i] = 0;
			shadow_atten[i] = 4'hF;
		end
		shadow_target = 0;
		make_pitch_bounds();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pitch extremes, bad select, retrigger, DAC channel, PSG limits
		fm_key(0, 4'hF);
		fm_key(0, 4'h0);
		fm_write(0, 8'hA4, 8'h3F);
		fm_write(0, 8'hA0, 8'hFF);
		fm_write(0, 8'h4C, 8'h7F);
		fm_key(0, 4'h1);
		fm_key(0, 4'hF);
		fm_key(0, 4'h0);
		fm_write(0, FM_KEY_REG[7:0], 8'hF3);
		fm_write(1, 8'hA6, 8'h01);
		fm_write(1, 8'hA2, 8'h00);
		fm_write(0, FM_DAC_REG[7:0], 8'h80);
		fm_key(5, 4'hF);
		fm_key(5, 4'h0);
		psg_period_set(0, 10'd8);
		psg_atten(0, 4'h0);
		psg_atten(0, 4'hF);
		psg_period_set(1, 10'h3FF);
		psg_atten(1, 4'hE);
		psg_atten(3, 4'h0);
		psg_atten(3, 4'hF);
		psg_atten(1, 4'hF);
		wait_drained();
		fm_write(0, FM_DAC_REG[7:0], 8'h00);

		// random: mostly patch, key on, key off; some noise words
		while (words_queued < 1000) begin
			if (words_queued > 850)
				quiet = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					ch = $urandom_range(0, 5);
					fm_voice_setup(ch, $urandom_range(0, 1));
					fm_key(ch, 4'($urandom_range(1, 15)));
					if ($urandom_range(0, 3) == 0)
						fm_key(ch, 4'($urandom_range(1, 15)));
					fm_key(ch, 4'h0);
				end
				4, 5, 6: begin
					ch = $urandom_range(0, 3);
					psg_period_set(ch, ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 9))
						: 10'($urandom));
					psg_atten(ch, 4'($urandom_range(0, 14)));
					psg_atten(ch, 4'($urandom));
					psg_atten(ch, 4'hF);
				end
				7:
					fm_write($urandom_range(0, 1), 8'($urandom_range('h30, 'hB6)), 8'($urandom));
				8:
					fm_write(0, FM_DAC_REG[7:0], 8'($urandom));
				default:
					queue_word(1'($urandom), 2'($urandom), 8'($urandom));
			endcase
			while (bus_pending.size() > 40)
				@(posedge clk);
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && notes_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
